// ===== rtl/sebt_pkg.sv =====
// sebt_pkg: shared types, character codes and helper functions for the
// S-expression byte tokenizer. No dependencies.
`default_nettype none
package sebt_pkg;

  // Width of the internal line and column counters.
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned REPORT_BITS   = 16;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [REPORT_BITS-1:0]   report_t;

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};
  localparam pos_t POS_ONE = pos_t'(1);

  // Character codes
  localparam logic [7:0] CH_OPEN    = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE   = 8'h29;  // )
  localparam logic [7:0] CH_SEMI    = 8'h3B;  // ;
  localparam logic [7:0] CH_MINUS   = 8'h2D;  // -
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // +
  localparam logic [7:0] CH_DOT     = 8'h2E;  // .
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_SYMBOL  = 2'd3
  } scan_mode_e;

  typedef enum logic [2:0] {
    KIND_SPACE   = 3'd0,
    KIND_COMMENT = 3'd1,
    KIND_OPEN    = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_NUMBER  = 3'd4,
    KIND_SYMBOL  = 3'd5
  } byte_kind_e;

  // Lexer state carried from byte to byte
  typedef struct packed {
    scan_mode_e mode;
    logic       decimal_seen;
  } scan_state_t;

  // Label for one byte
  typedef struct packed {
    byte_kind_e kind;
    logic       starts_token;
  } byte_label_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Clamp a counter to the reported width
  function automatic report_t clamp_report(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? {REPORT_BITS{1'b1}} : w[REPORT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/s_expression_byte_tokenizer.sv =====
// s_expression_byte_tokenizer: top level; input stage, lexer state,
// position counters and result register. Depends on sebt_pkg,
// sebt_classify and sebt_position.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid_i, in_ready_o, text_byte_i,            | in
//          | end_of_text_i                                   |
//  out     | out_valid_o, out_ready_i, byte_kind_o,          | out
//          | starts_token_o, line_number_o, column_number_o, |
//          | last_byte_o                                     |
//
// One byte per cycle sustained while out_ready_i is high. A request is
// captured in the input stage, labeled by the classifier against the lexer
// state and written into the result register once that register is free or
// draining; out_valid_o comes from the result register.
// Reset clears both stage valids, puts the lexer idle and the
// counters at line 1, column 1; an end-of-text byte returns the lexer and
// counters to those values after it is labeled. When out_ready_i is low the
// result holds, the input stage fills, and then in_ready_o drops.
`default_nettype none
module s_expression_byte_tokenizer import sebt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  byte_kind_o,
  output logic        starts_token_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic        last_byte_o
);

  // Input stage
  logic       stage_valid_q;
  logic [7:0] stage_byte_q;
  logic       stage_eot_q;

  // Lexer state and position counters
  scan_state_t state_q, state_d, state_next;
  pos_t        line_q, line_d, line_next;
  pos_t        column_q, column_d, column_next;

  // Result register
  logic        out_valid_q;
  byte_label_t out_label_q;
  report_t     out_line_q, out_column_q;
  logic        out_eot_q;

  byte_label_t label;
  logic        in_accept;
  logic        advance;

  // The stage moves on whenever the result register is free or draining.
  assign advance    = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  sebt_classify u_classify (
    .text_byte_i (stage_byte_q),
    .state_i     (state_q),
    .label_o     (label),
    .state_o     (state_next)
  );

  sebt_position u_position (
    .text_byte_i (stage_byte_q),
    .line_i      (line_q),
    .column_i    (column_q),
    .line_o      (line_next),
    .column_o    (column_next)
  );

  // State update; end of text returns everything to the reset values.
  always_comb begin
    state_d  = state_q;
    line_d   = line_q;
    column_d = column_q;
    if (advance) begin
      if (stage_eot_q) begin
        state_d  = '{mode: MODE_IDLE, decimal_seen: 1'b0};
        line_d   = POS_ONE;
        column_d = POS_ONE;
      end else begin
        state_d  = state_next;
        line_d   = line_next;
        column_d = column_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= '{mode: MODE_IDLE, decimal_seen: 1'b0};
      line_q        <= POS_ONE;
      column_q      <= POS_ONE;
    end else begin
      if (in_accept) begin
        stage_valid_q <= 1'b1;
      end else if (advance) begin
        stage_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      state_q  <= state_d;
      line_q   <= line_d;
      column_q <= column_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_byte_q <= text_byte_i;
      stage_eot_q  <= end_of_text_i;
    end
    if (advance) begin
      out_label_q  <= label;
      out_line_q   <= clamp_report(line_q);
      out_column_q <= clamp_report(column_q);
      out_eot_q    <= stage_eot_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_kind_o     = out_label_q.kind;
  assign starts_token_o  = out_label_q.starts_token;
  assign line_number_o   = out_line_q;
  assign column_number_o = out_column_q;
  assign last_byte_o     = out_eot_q;

  // Counters never leave the 1-based range
  a_counts_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q != '0) && (column_q != '0))
    else $error("line or column counter reached zero");

  // End of text returns lexer and counters to their reset values
  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_eot_q) |=>
      (state_q.mode == MODE_IDLE) && !state_q.decimal_seen &&
      (line_q == POS_ONE) && (column_q == POS_ONE))
    else $error("state not reset after end of text");

  // Only parens, numbers and symbols start a token
  a_start_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_label_q.starts_token) |->
      (out_label_q.kind == KIND_OPEN) || (out_label_q.kind == KIND_CLOSE) ||
      (out_label_q.kind == KIND_NUMBER) || (out_label_q.kind == KIND_SYMBOL))
    else $error("token start on a space or comment byte");

  // A decimal point is only remembered inside a number
  a_decimal_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.decimal_seen |-> (state_q.mode == MODE_NUMBER))
    else $error("decimal flag set outside a number");

endmodule
`default_nettype wire

// ===== rtl/sebt_classify.sv =====
// sebt_classify: labels one byte and computes the next lexer state.
// Depends on sebt_pkg.
`default_nettype none
module sebt_classify import sebt_pkg::*; (
  input  logic [7:0]  text_byte_i,
  input  scan_state_t state_i,
  output byte_label_t label_o,
  output scan_state_t state_o
);

  logic handled;
  logic delim;

  assign delim = (text_byte_i == CH_OPEN) || (text_byte_i == CH_CLOSE) ||
                 (text_byte_i == CH_SEMI) || is_space(text_byte_i);

  always_comb begin
    label_o = '{kind: KIND_SPACE, starts_token: 1'b0};
    state_o = state_i;
    handled = 1'b0;

    // Continue the current token
    case (state_i.mode)
      MODE_COMMENT: begin
        if (text_byte_i != CH_NEWLINE) begin
          label_o.kind = KIND_COMMENT;
          handled      = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if ((text_byte_i == CH_DOT) && !state_i.decimal_seen) begin
          state_o.decimal_seen = 1'b1;
          label_o.kind         = KIND_NUMBER;
          handled              = 1'b1;
        end else if (is_digit(text_byte_i)) begin
          label_o.kind = KIND_NUMBER;
          handled      = 1'b1;
        end
      end
      MODE_SYMBOL: begin
        if (!delim) begin
          label_o.kind = KIND_SYMBOL;
          handled      = 1'b1;
        end
      end
      default: ;
    endcase

    // Between tokens
    if (!handled) begin
      state_o = '{mode: MODE_IDLE, decimal_seen: 1'b0};
      if (is_space(text_byte_i)) begin
        label_o.kind = KIND_SPACE;
      end else if (text_byte_i == CH_OPEN) begin
        label_o = '{kind: KIND_OPEN, starts_token: 1'b1};
      end else if (text_byte_i == CH_CLOSE) begin
        label_o = '{kind: KIND_CLOSE, starts_token: 1'b1};
      end else if (text_byte_i == CH_SEMI) begin
        label_o.kind = KIND_COMMENT;
        state_o.mode = MODE_COMMENT;
      end else if (is_digit(text_byte_i) || (text_byte_i == CH_PLUS) ||
                   (text_byte_i == CH_MINUS)) begin
        label_o      = '{kind: KIND_NUMBER, starts_token: 1'b1};
        state_o.mode = MODE_NUMBER;
      end else begin
        label_o      = '{kind: KIND_SYMBOL, starts_token: 1'b1};
        state_o.mode = MODE_SYMBOL;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sebt_position.sv =====
// sebt_position: next line and column counts after one byte, saturating.
// Depends on sebt_pkg.
`default_nettype none
module sebt_position import sebt_pkg::*; (
  input  logic [7:0] text_byte_i,
  input  pos_t       line_i,
  input  pos_t       column_i,
  output pos_t       line_o,
  output pos_t       column_o
);

  always_comb begin
    line_o   = line_i;
    column_o = column_i;
    if (text_byte_i == CH_NEWLINE) begin
      if (line_i != POS_MAX) begin
        line_o = line_i + POS_ONE;
      end
      column_o = POS_ONE;
    end else if (column_i != POS_MAX) begin
      column_o = column_i + POS_ONE;
    end
  end

endmodule
`default_nettype wire
